FILE: hw/rtl/mnd_pkg.sv
// ============================================================================
// mnd_pkg
// Shared types and constants for the MIDI note event decoder.
// ============================================================================
`default_nettype none

package mnd_pkg;

    localparam logic [3:0]  TypeNoteOff = 4'h8;
    localparam logic [3:0]  TypeNoteOn  = 4'h9;
    localparam logic [3:0]  TypeBend    = 4'hE;

    localparam logic [4:0]  RangeReset  = 5'd2;
    localparam logic [5:0]  RangeBias   = 6'd12;
    // 2^28 = 3 * ThirdQ + 1, so (12 + range) * 2^30 / 12 becomes a multiply.
    localparam logic [26:0] ThirdQ      = 27'd89478485;
    // Reciprocal of three in Q9, exact for the small remainders used here.
    localparam logic [7:0]  ThirdRecip  = 8'd171;
    localparam logic [31:0] Q30One      = 32'h4000_0000;
    localparam logic [63:0] Q30Half     = 64'h0000_0000_2000_0000;
    localparam logic [32:0] Q14Half     = 33'h0_0000_2000;
    localparam logic [13:0] BendFlip    = 14'h2000;
    localparam logic [14:0] BendSpan    = 15'h4000;
    localparam logic [47:0] InvNumer    = 48'h4000_0000_0000;
    localparam int          RootCount   = 14;
    localparam logic [3:0]  LastRoot    = 4'd13;

    // Equal-tempered note frequency in whole hertz, truncated.
    localparam logic [13:0] NoteBaseHz [128] = '{
        14'd8,    14'd8,    14'd9,    14'd9,    14'd10,   14'd10,
        14'd11,   14'd12,   14'd12,   14'd13,   14'd14,   14'd15,
        14'd16,   14'd17,   14'd18,   14'd19,   14'd20,   14'd21,
        14'd23,   14'd24,   14'd25,   14'd27,   14'd29,   14'd30,
        14'd32,   14'd34,   14'd36,   14'd38,   14'd41,   14'd43,
        14'd46,   14'd48,   14'd51,   14'd55,   14'd58,   14'd61,
        14'd65,   14'd69,   14'd73,   14'd77,   14'd82,   14'd87,
        14'd92,   14'd97,   14'd103,  14'd110,  14'd116,  14'd123,
        14'd130,  14'd138,  14'd146,  14'd155,  14'd164,  14'd174,
        14'd184,  14'd195,  14'd207,  14'd220,  14'd233,  14'd246,
        14'd261,  14'd277,  14'd293,  14'd311,  14'd329,  14'd349,
        14'd369,  14'd391,  14'd415,  14'd440,  14'd466,  14'd493,
        14'd523,  14'd554,  14'd587,  14'd622,  14'd659,  14'd698,
        14'd739,  14'd783,  14'd830,  14'd880,  14'd932,  14'd987,
        14'd1046, 14'd1108, 14'd1174, 14'd1244, 14'd1318, 14'd1396,
        14'd1479, 14'd1567, 14'd1661, 14'd1760, 14'd1864, 14'd1975,
        14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2793,
        14'd2959, 14'd3135, 14'd3322, 14'd3520, 14'd3729, 14'd3951,
        14'd4186, 14'd4434, 14'd4698, 14'd4978, 14'd5274, 14'd5587,
        14'd5919, 14'd6271, 14'd6644, 14'd7040, 14'd7458, 14'd7902,
        14'd8372, 14'd8869, 14'd9397, 14'd9956, 14'd10548, 14'd11175,
        14'd11839, 14'd12543
    };

    typedef struct packed {
        logic accept;
        logic ld_x;
        logic sqrt_start;
        logic sqrt_from_x;
        logic ld_root;
        logic mul_a;
        logic mul_b;
        logic div_n_start;
        logic ld_pos_mult;
        logic ld_inv_mult;
        logic freq_mul;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic note_go;
        logic div_done;
        logic sqrt_done;
        logic last_root;
        logic last_bit;
        logic neg;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/mnd_div.sv
// ============================================================================
// mnd_div
// Restoring divider, one quotient bit per cycle, 48-bit by 32-bit.
// ============================================================================
`default_nettype none

module mnd_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [47:0]      o_quotient
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [47:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [32:0] w_rem2;
    logic        w_ge;

    assign w_rem2 = {r_rem, r_q[47]};
    assign w_ge   = w_rem2 >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= 32'(w_rem2 - {1'b0, r_div});
            end else begin
                r_rem <= w_rem2[31:0];
            end
            r_q <= {r_q[46:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mnd_isqrt.sv
// ============================================================================
// mnd_isqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ============================================================================
`default_nettype none

module mnd_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_radicand,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] w_rem2;
    logic [34:0] w_trial;
    logic        w_ge;

    // The remainder never exceeds twice the root, so 33 bits carry it.
    assign w_rem2  = {r_rem[32:0], r_rad[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = w_rem2 >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[61:0], 2'b00};
            if (w_ge) begin
                r_rem  <= w_rem2 - w_trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= w_rem2;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: hw/rtl/mnd_ctrl.sv
// ============================================================================
// mnd_ctrl
// Sequencer for item intake and the frequency computation of a note event.
// ============================================================================
`default_nettype none

module mnd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mnd_pkg::t_sts i_sts,
    output mnd_pkg::t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SQRT = 8'b00000010,
        S_MULA = 8'b00000100,
        S_MULB = 8'b00001000,
        S_POST = 8'b00010000,
        S_DIVN = 8'b00100000,
        S_FREQ = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.accept = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_sts.note_go) begin
                    o_cmd.ld_x        = 1'b1;
                    o_cmd.sqrt_start  = 1'b1;
                    o_cmd.sqrt_from_x = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.ld_root = 1'b1;
                    if (i_sts.last_root) begin
                        n_state = S_MULA;
                    end else begin
                        o_cmd.sqrt_start = 1'b1;
                    end
                end
            end
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state = i_sts.last_bit ? S_POST : S_MULA;
            end
            S_POST: begin
                if (i_sts.neg) begin
                    o_cmd.div_n_start = 1'b1;
                    n_state = S_DIVN;
                end else begin
                    o_cmd.ld_pos_mult = 1'b1;
                    n_state = S_FREQ;
                end
            end
            S_DIVN: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_inv_mult = 1'b1;
                    n_state = S_FREQ;
                end
            end
            S_FREQ: begin
                o_cmd.freq_mul = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state is not one-hot");

    a_sqrt_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && !i_sts.sqrt_done) |=> r_state == S_SQRT)
        else $error("left root stage before the root was ready");

    a_note_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sts.note_go) |=> r_state == S_SQRT)
        else $error("note dispatch did not start the computation");

endmodule

`default_nettype wire

FILE: hw/rtl/mnd_dp.sv
// ============================================================================
// mnd_dp
// Datapath: message parser, bend store, root chain, multiplier and output.
// ============================================================================
`default_nettype none

module mnd_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_type,
    input  wire logic [7:0]    i_byte_value,
    input  wire logic          i_cfg_we,
    input  wire logic [4:0]    i_cfg_wdata,
    input  wire logic          i_out_ready,
    input  wire mnd_pkg::t_cmd i_cmd,
    output mnd_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output logic               o_event_kind,
    output logic [3:0]         o_channel,
    output logic [6:0]         o_note_number,
    output logic [6:0]         o_velocity,
    output logic [15:0]        o_frequency_hz
);

    // Parser state and configuration.
    logic [4:0]  r_range;
    logic [3:0]  r_type, r_chan;
    logic [1:0]  r_count;
    logic [7:0]  r_d1, r_d2;
    logic [13:0] r_bend_tab [16];

    // Event being computed.
    logic        r_ev_kind;
    logic [3:0]  r_ev_chan;
    logic [6:0]  r_ev_note, r_ev_vel;
    logic [13:0] r_bend;
    logic [31:0] r_roots [mnd_pkg::RootCount];
    logic [3:0]  r_k, r_j;
    logic [31:0] r_p;
    logic [63:0] r_prod;
    logic [18:0] r_mult;
    logic [32:0] r_fprod;

    // Output register.
    logic        r_out_valid, r_o_kind;
    logic [3:0]  r_o_chan;
    logic [6:0]  r_o_note, r_o_vel;
    logic [15:0] r_o_freq;

    logic        w_is_note, w_tick_full;
    logic [13:0] w_m;
    logic [63:0] w_round;
    logic [32:0] w_pos;
    logic [5:0]  w_rsum, w_rsum1;
    logic [31:0] w_xmul, w_x;
    logic [13:0] w_xfrac;
    logic        div_done, sqrt_done;
    logic [47:0] div_dividend, div_q;
    logic [31:0] sqrt_root, sqrt_src;
    logic [3:0]  w_ridx;

    assign w_is_note   = (r_type == mnd_pkg::TypeNoteOn) || (r_type == mnd_pkg::TypeNoteOff);
    assign w_tick_full = i_req_type && (r_count == 2'd3);

    // A negative bend uses its magnitude, up to a full 8192.
    assign w_m = r_bend[13] ? 14'(mnd_pkg::BendSpan - {1'b0, r_bend})
                            : {1'b0, r_bend[12:0]};

    assign w_round = r_prod + mnd_pkg::Q30Half;
    assign w_pos   = {1'b0, r_p} + mnd_pkg::Q14Half;
    assign w_rsum  = mnd_pkg::RangeBias + {1'b0, r_range};
    assign w_ridx  = mnd_pkg::LastRoot - r_j;

    // Rounded (12 + range) / 12 in Q30 equals (12 + range) * ThirdQ plus
    // floor((13 + range) / 3), the latter taken by a reciprocal multiply.
    assign w_rsum1 = w_rsum + 6'd1;
    assign w_xmul  = {26'b0, w_rsum} * {5'b0, mnd_pkg::ThirdQ};
    assign w_xfrac = {8'b0, w_rsum1} * {6'b0, mnd_pkg::ThirdRecip};
    assign w_x     = w_xmul + {27'b0, w_xfrac[13:9]};

    assign div_dividend = mnd_pkg::InvNumer + {17'b0, r_p[31:1]};
    assign sqrt_src     = i_cmd.sqrt_from_x ? w_x : sqrt_root;

    mnd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_n_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_p),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    mnd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand ({2'b00, sqrt_src, 30'b0}),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    always_comb begin
        o_sts.note_go   = w_tick_full && w_is_note;
        o_sts.div_done  = div_done;
        o_sts.sqrt_done = sqrt_done;
        o_sts.last_root = (r_k == mnd_pkg::LastRoot);
        o_sts.last_bit  = (r_j == mnd_pkg::LastRoot);
        o_sts.neg       = r_bend[13];
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // Parser, configuration and bend store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= mnd_pkg::RangeReset;
            r_type  <= '0;
            r_chan  <= '0;
            r_count <= '0;
            r_d1    <= '0;
            r_d2    <= '0;
            for (int i = 0; i < 16; i++) begin
                r_bend_tab[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_range <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                if (!i_req_type) begin
                    priority if (i_byte_value[7]) begin
                        r_type  <= i_byte_value[7:4];
                        r_chan  <= i_byte_value[3:0];
                        r_count <= 2'd1;
                    end else if (r_count == 2'd0) begin
                        r_count <= 2'd1;
                    end else if (r_count == 2'd1) begin
                        r_d1    <= i_byte_value;
                        r_count <= 2'd2;
                    end else if (r_count == 2'd2) begin
                        r_d2    <= i_byte_value;
                        r_count <= 2'd3;
                    end else begin
                        // A full message ignores further data bytes.
                        r_count <= r_count;
                    end
                end else if (r_count != 2'd0) begin
                    // Note and bend messages wait until they are complete.
                    if (w_is_note || r_type == mnd_pkg::TypeBend) begin
                        if (r_count == 2'd3) begin
                            r_count <= 2'd0;
                            if (r_type == mnd_pkg::TypeBend) begin
                                r_bend_tab[r_chan] <= {r_d2[6:0], r_d1[6:0]}
                                                      ^ mnd_pkg::BendFlip;
                            end
                        end
                    end else begin
                        r_count <= 2'd0;
                    end
                end
            end
        end
    end

    // Frequency computation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_sts.note_go) begin
            r_ev_kind <= (r_type == mnd_pkg::TypeNoteOn);
            r_ev_chan <= r_chan;
            r_ev_note <= r_d1[6:0];
            r_ev_vel  <= r_d2[6:0];
            r_bend    <= r_bend_tab[r_chan];
            r_p       <= mnd_pkg::Q30One;
            r_j       <= '0;
        end
        if (i_cmd.ld_x) begin
            r_roots[0] <= w_x;
            r_k        <= 4'd1;
        end
        if (i_cmd.ld_root) begin
            r_roots[r_k] <= sqrt_root;
            r_k          <= r_k + 4'd1;
        end
        if (i_cmd.mul_a) begin
            r_prod <= r_p * r_roots[w_ridx];
        end
        if (i_cmd.mul_b) begin
            if (w_m[r_j]) begin
                r_p <= w_round[61:30];
            end
            r_j <= r_j + 4'd1;
        end
        if (i_cmd.ld_pos_mult) begin
            r_mult <= w_pos[32:14];
        end
        if (i_cmd.ld_inv_mult) begin
            r_mult <= div_q[18:0];
        end
        if (i_cmd.freq_mul) begin
            r_fprod <= mnd_pkg::NoteBaseHz[r_ev_note] * r_mult;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_kind <= r_ev_kind;
            r_o_chan <= r_ev_chan;
            r_o_note <= r_ev_note;
            r_o_vel  <= r_ev_vel;
            r_o_freq <= r_fprod[32] ? 16'hFFFF : r_fprod[31:16];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_o_kind;
    assign o_channel      = r_o_chan;
    assign o_note_number  = r_o_note;
    assign o_velocity     = r_o_vel;
    assign o_frequency_hz = r_o_freq;

endmodule

`default_nettype wire

FILE: hw/rtl/midi_note_event_decoder.sv
// ============================================================================
// midi_note_event_decoder
// Parses MIDI channel messages and emits note events with bent frequency.
// ============================================================================
// Byte items and ticks that emit nothing are taken whenever the controller is idle.
// A note tick shows its event after thirteen square roots on the bit-serial
// root unit, fourteen multiply steps and, for a downward bend, one divide.
// Synchronous active-low reset clears the parser, bend store, range (to 2).
`default_nettype none

module midi_note_event_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_event_kind,
    output logic [3:0]       o_channel,
    output logic [6:0]       o_note_number,
    output logic [6:0]       o_velocity,
    output logic [15:0]      o_frequency_hz
);

    mnd_pkg::t_cmd cmd;
    mnd_pkg::t_sts sts;

    mnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mnd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_byte_value   (i_byte_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (i_out_ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_event_kind   (o_event_kind),
        .o_channel      (o_channel),
        .o_note_number  (o_note_number),
        .o_velocity     (o_velocity),
        .o_frequency_hz (o_frequency_hz)
    );

endmodule

`default_nettype wire
